>>> sv/esfrl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the engine speed filter and rev limiter.
// No dependencies; used by every module of the block.
package esfrl_pkg;

    localparam int NUM_CHANNELS  = 8;
    localparam int MAX_CHANNELS  = 8;
    localparam int RPM_W         = 16;
    localparam int TRANS_W       = 8;
    localparam int APB_ADDR_W    = 6;
    localparam int APB_DATA_W    = 64;
    localparam int IN_DATA_W     = 24;
    localparam int OUT_DATA_W    = 56;

    // Register map, indexed by paddr[5:3]
    localparam logic [2:0] REG_LIMITS_LOW  = 3'd0;
    localparam logic [2:0] REG_LIMITS_HIGH = 3'd1;
    localparam logic [2:0] REG_HYSTERESIS  = 3'd2;
    localparam logic [2:0] REG_TIMEOUT     = 3'd3;
    localparam logic [2:0] REG_RELOAD      = 3'd4;

    localparam logic [63:0]      LIMITS_RESET     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [RPM_W-1:0] HYST_RESET       = 16'd200;
    localparam logic [RPM_W-1:0] TIMEOUT_RESET    = 16'd100;
    localparam logic [TRANS_W-1:0] RELOAD_RESET   = 8'd10;

    // Error below this keeps the filter in its steady weighting
    localparam logic [RPM_W:0] SMALL_ERROR = 17'd150;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_EVENT = 1'b1;

    typedef struct packed {
        logic [127:0]         rev_limits;   // channel i at bits 16*i +: 16
        logic [RPM_W-1:0]     hysteresis;
        logic [RPM_W-1:0]     timeout_ticks;
        logic [TRANS_W-1:0]   reload;
    } cfg_t;

    typedef struct packed {
        logic                 mode;
        logic [RPM_W-1:0]     rpm_in;
        logic                 throttle_closed;
    } item_t;

    typedef struct packed {
        logic [MAX_CHANNELS-1:0] cut_flags;
        logic [RPM_W-1:0]        filtered_rpm;
        logic [RPM_W-1:0]        raw_rpm;
        logic [TRANS_W-1:0]      transition_level;
        logic                    speed_lost;
    } result_t;

endpackage

>>> sv/esfrl_regs.sv
`timescale 1ns / 1ps
// APB register file holding the rev limits, hysteresis, timeout and reload.
// Depends on esfrl_pkg.
module esfrl_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [esfrl_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [esfrl_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [esfrl_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    output esfrl_pkg::cfg_t                     cfg
);

    logic [63:0] limits_low_reg;
    logic [63:0] limits_high_reg;
    logic [esfrl_pkg::RPM_W-1:0]   hyst_reg;
    logic [esfrl_pkg::RPM_W-1:0]   timeout_reg;
    logic [esfrl_pkg::TRANS_W-1:0] reload_reg;
    logic        wr_en;
    logic [2:0]  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_low_reg  <= esfrl_pkg::LIMITS_RESET;
            limits_high_reg <= esfrl_pkg::LIMITS_RESET;
            hyst_reg        <= esfrl_pkg::HYST_RESET;
            timeout_reg     <= esfrl_pkg::TIMEOUT_RESET;
            reload_reg      <= esfrl_pkg::RELOAD_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                esfrl_pkg::REG_LIMITS_LOW:  limits_low_reg  <= pwdata;
                esfrl_pkg::REG_LIMITS_HIGH: limits_high_reg <= pwdata;
                esfrl_pkg::REG_HYSTERESIS:  hyst_reg        <= pwdata[15:0];
                esfrl_pkg::REG_TIMEOUT:     timeout_reg     <= pwdata[15:0];
                esfrl_pkg::REG_RELOAD:      reload_reg      <= pwdata[7:0];
                default: ;  // drop writes outside the map
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            esfrl_pkg::REG_LIMITS_LOW:  prdata = limits_low_reg;
            esfrl_pkg::REG_LIMITS_HIGH: prdata = limits_high_reg;
            esfrl_pkg::REG_HYSTERESIS:  prdata = {48'd0, hyst_reg};
            esfrl_pkg::REG_TIMEOUT:     prdata = {48'd0, timeout_reg};
            esfrl_pkg::REG_RELOAD:      prdata = {56'd0, reload_reg};
            default:                    prdata = '0;
        endcase
    end

    assign cfg.rev_limits    = {limits_high_reg, limits_low_reg};
    assign cfg.hysteresis    = hyst_reg;
    assign cfg.timeout_ticks = timeout_reg;
    assign cfg.reload        = reload_reg;

endmodule

>>> sv/esfrl_core.sv
`timescale 1ns / 1ps
// Speed filter, timeout and rev-cut state with its combinational update.
// Depends on esfrl_pkg.
module esfrl_core #(
    parameter int NUM_CHANNELS = esfrl_pkg::NUM_CHANNELS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  esfrl_pkg::item_t    item,
    input  esfrl_pkg::cfg_t     cfg,
    output esfrl_pkg::result_t  result
);

    logic [esfrl_pkg::RPM_W-1:0]   raw_speed_reg, raw_speed_next;
    logic [esfrl_pkg::RPM_W-1:0]   smoothed_reg, smoothed_next;
    logic [esfrl_pkg::TRANS_W-1:0] trans_count_reg, trans_count_next;
    logic [esfrl_pkg::RPM_W-1:0]   timeout_count_reg, timeout_count_next;
    logic [NUM_CHANNELS-1:0]       cut_state_reg, cut_state_next;

    always_comb
    begin
        logic [esfrl_pkg::RPM_W:0]   diff;
        logic [esfrl_pkg::RPM_W:0]   err;
        logic [esfrl_pkg::RPM_W+2:0] slow_sum;
        logic [esfrl_pkg::RPM_W:0]   half_sum;
        logic [esfrl_pkg::RPM_W-1:0] raw_tick;
        logic [esfrl_pkg::RPM_W-1:0] lim;
        logic signed [esfrl_pkg::RPM_W:0] thresh;

        raw_speed_next     = raw_speed_reg;
        smoothed_next      = smoothed_reg;
        trans_count_next   = trans_count_reg;
        timeout_count_next = timeout_count_reg;
        cut_state_next     = cut_state_reg;

        diff = {1'b0, item.rpm_in} - {1'b0, smoothed_reg};
        err  = diff[esfrl_pkg::RPM_W] ? (~diff + 17'd1) : diff;
        // raw + 7*smoothed, with 7*s formed as 8*s - s
        slow_sum = {3'b000, item.rpm_in} + {smoothed_reg, 3'b000}
                   - {3'b000, smoothed_reg};
        half_sum = {1'b0, item.rpm_in} + {1'b0, smoothed_reg};

        raw_tick = (timeout_count_reg < cfg.timeout_ticks) ? raw_speed_reg : '0;
        lim      = '0;
        thresh   = '0;

        if (item.mode == esfrl_pkg::MODE_EVENT)
        begin
            raw_speed_next     = item.rpm_in;
            timeout_count_next = '0;
            if (err < esfrl_pkg::SMALL_ERROR)
            begin
                smoothed_next = item.throttle_closed ? slow_sum[esfrl_pkg::RPM_W+2:3]
                                                     : half_sum[esfrl_pkg::RPM_W:1];
                if (trans_count_reg != '0)
                    trans_count_next = trans_count_reg - 8'd1;
            end
            else
            begin
                smoothed_next    = half_sum[esfrl_pkg::RPM_W:1];
                trans_count_next = cfg.reload;
            end
        end
        else
        begin
            raw_speed_next = raw_tick;
            if (timeout_count_reg < cfg.timeout_ticks)
                timeout_count_next = timeout_count_reg + 16'd1;
            for (int ch = 0; ch < NUM_CHANNELS; ch++)
            begin
                lim    = cfg.rev_limits[ch*16 +: 16];
                thresh = $signed({1'b0, lim}) - $signed({1'b0, cfg.hysteresis});
                if (lim < raw_tick)
                    cut_state_next[ch] = 1'b1;
                else if (thresh > $signed({1'b0, raw_tick}))
                    cut_state_next[ch] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_speed_reg     <= '0;
            smoothed_reg      <= '0;
            trans_count_reg   <= '0;
            timeout_count_reg <= '0;
            cut_state_reg     <= '0;
        end
        else if (adv)
        begin
            raw_speed_reg     <= raw_speed_next;
            smoothed_reg      <= smoothed_next;
            trans_count_reg   <= trans_count_next;
            timeout_count_reg <= timeout_count_next;
            cut_state_reg     <= cut_state_next;
        end
    end

    // State after this item's update, for the result register
    assign result.cut_flags        = esfrl_pkg::MAX_CHANNELS'(cut_state_next);
    assign result.filtered_rpm     = smoothed_next;
    assign result.raw_rpm          = raw_speed_next;
    assign result.transition_level = trans_count_next;
    assign result.speed_lost       = (timeout_count_next >= cfg.timeout_ticks);

    a_event_clears_timeout: assert property (@(posedge clk) disable iff (!rst_n)
        adv && item.mode == esfrl_pkg::MODE_EVENT |=> timeout_count_reg == '0)
        else $error("speed event did not clear the timeout counter");

    a_expired_tick_zeroes_raw: assert property (@(posedge clk) disable iff (!rst_n)
        adv && item.mode == esfrl_pkg::MODE_TICK
        && timeout_count_reg >= cfg.timeout_ticks |=> raw_speed_reg == '0)
        else $error("expired tick left raw speed non-zero");

    a_hold_without_adv: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(smoothed_reg) && $stable(cut_state_reg))
        else $error("state changed without an item");

    a_tick_keeps_filter: assert property (@(posedge clk) disable iff (!rst_n)
        adv && item.mode == esfrl_pkg::MODE_TICK |=> $stable(smoothed_reg))
        else $error("tick changed the filtered speed");

endmodule

>>> sv/engine_speed_filter_rev_limiter.sv
`timescale 1ns / 1ps
// Engine speed filter and per-channel rev limiter, top level.
// Channels:
//   s_axis_*  input items: tuser is the mode (0 tick, 1 speed event), tdata
//             carries rpm_in and throttle_closed.
//   m_axis_*  one result per item: cut flags, filtered speed, raw speed,
//             transition level and speed-lost flag, all taken after the update.
//   APB       configuration, 64-bit data, register i at byte address 8*i;
//             write only while no item is in flight.
// The input register loads at the input transaction and the result register
// loads from it when the block advances. Throughput: one item per cycle while
// the receiver does not stall; the filter, timeout and eight limit compares
// update their state combinationally between the input and result registers.
// Reset clears the speed, filter, counters and cut flags and loads the
// register reset values; both valid flags drop.
// When the receiver stalls the result register holds, the input register
// still takes one more item, and s_axis_tready then drops until the result
// is taken. Depends on esfrl_pkg, esfrl_regs and esfrl_core.
module engine_speed_filter_rev_limiter #(
    parameter int NUM_CHANNELS = esfrl_pkg::NUM_CHANNELS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] rpm_in, [16] throttle_closed, [23:17] zero
    input  logic [esfrl_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] mode
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] cut_flags, [23:8] filtered_rpm, [39:24] raw_rpm,
    // [47:40] transition_level, [48] speed_lost, [55:49] zero
    output logic [esfrl_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [esfrl_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [esfrl_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [esfrl_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    esfrl_pkg::cfg_t    cfg;
    esfrl_pkg::item_t   item_reg;
    esfrl_pkg::result_t result;
    esfrl_pkg::result_t result_reg;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic               adv;
    logic               in_take;

    esfrl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Advance when the result register is free or being emptied
    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (adv)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.mode            <= s_axis_tuser;
            item_reg.rpm_in          <= s_axis_tdata[15:0];
            item_reg.throttle_closed <= s_axis_tdata[16];
        end
        if (adv)
            result_reg <= result;
    end

    esfrl_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0,
                            result_reg.speed_lost,
                            result_reg.transition_level,
                            result_reg.raw_rpm,
                            result_reg.filtered_rpm,
                            result_reg.cut_flags};

endmodule
